[hw/rtl/ghash_pkg.sv]
`default_nettype none

package ghash_pkg;

  localparam int unsigned BlockW   = 128;
  localparam int unsigned HalfW    = 64;
  localparam int unsigned DigitW   = 8;
  localparam int unsigned NumSteps = BlockW / DigitW;
  localparam int unsigned CntW     = $clog2(NumSteps);

  // reduction constant: 0xE1 followed by 120 zero bits
  localparam logic [BlockW-1:0] RedPoly = {8'hE1, {(BlockW-8){1'b0}}};

  // register indexes on the configuration port
  localparam logic RegKeyHi = 1'b0;
  localparam logic RegKeyLo = 1'b1;

  typedef logic [BlockW-1:0] block_t;

endpackage

`default_nettype wire

[hw/rtl/ghash_accumulator.sv]
`default_nettype none

// Channel  Handshake                  Payload
// in_      in_valid / in_ready        in_block_hi, in_block_lo, in_first_block
// out_     out_valid / out_ready      out_hash_hi, out_hash_lo
// cfg_     APB, pready tied high      cfg_paddr[3:0], cfg_pwdata/prdata 64 bit
//
// A word is first loaded into the multiplier, then goes through 16
// steps of an 8-bit digit-serial GF(2^128) multiply against H.
// Input is taken only while the multiplier is idle.
// The last step waits while an earlier result has not been taken by out_ready.
// rst_n is synchronous; it clears H, the accumulator and all control state.
module ghash_accumulator (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [63:0] in_block_hi,
  input  wire logic [63:0] in_block_lo,
  input  wire logic        in_first_block,

  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [63:0] out_hash_hi,
  output logic      [63:0] out_hash_lo,

  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [63:0] cfg_pwdata,
  output logic      [63:0] cfg_prdata,
  output logic             cfg_pready
);

  logic [ghash_pkg::HalfW-1:0] key_hi_r, key_lo_r;
  ghash_pkg::block_t           acc_r, acc_nxt;
  ghash_pkg::block_t           x_r, x_nxt;
  ghash_pkg::block_t           z_r, z_nxt;
  ghash_pkg::block_t           v_r, v_nxt;
  ghash_pkg::block_t           z_step, v_step;
  ghash_pkg::block_t           sum;
  logic [ghash_pkg::CntW-1:0]  cnt_r, cnt_nxt;
  logic                        busy_r, busy_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        cfg_wr, in_acc, last, finish;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[3] == ghash_pkg::RegKeyLo) ? key_lo_r : key_hi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_hi_r <= '0;
      key_lo_r <= '0;
    end else if (cfg_wr) begin
      if (cfg_paddr[3] == ghash_pkg::RegKeyHi) begin
        key_hi_r <= cfg_pwdata;
      end else begin
        key_lo_r <= cfg_pwdata;
      end
    end
  end

  assign in_ready  = ~busy_r;
  assign in_acc    = in_valid & ~busy_r;
  assign out_valid = out_valid_r;
  assign out_hash_hi = acc_r[ghash_pkg::BlockW-1:ghash_pkg::HalfW];
  assign out_hash_lo = acc_r[ghash_pkg::HalfW-1:0];

  assign last   = (cnt_r == ghash_pkg::CntW'(ghash_pkg::NumSteps - 1));
  assign finish = busy_r & last & (~out_valid_r | out_ready);

  // a first word starts from a cleared accumulator
  assign sum = (in_first_block ? '0 : acc_r) ^ {in_block_hi, in_block_lo};

  // one digit: add shifted H where the x bit is set, advance H by x each bit
  always_comb begin
    z_step = z_r;
    v_step = v_r;
    for (int i = 0; i < ghash_pkg::DigitW; i++) begin
      if (x_r[ghash_pkg::BlockW-1-i]) begin
        z_step = z_step ^ v_step;
      end
      v_step = {1'b0, v_step[ghash_pkg::BlockW-1:1]} ^
               (v_step[0] ? ghash_pkg::RedPoly : '0);
    end
  end

  always_comb begin
    x_nxt         = x_r;
    z_nxt         = z_r;
    v_nxt         = v_r;
    cnt_nxt       = cnt_r;
    busy_nxt      = busy_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    if (in_acc) begin
      x_nxt    = sum;
      z_nxt    = '0;
      v_nxt    = {key_hi_r, key_lo_r};
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!last) begin
        x_nxt   = {x_r[ghash_pkg::BlockW-ghash_pkg::DigitW-1:0],
                   {ghash_pkg::DigitW{1'b0}}};
        z_nxt   = z_step;
        v_nxt   = v_step;
        cnt_nxt = cnt_r + 1'b1;
      end else if (finish) begin
        acc_nxt       = z_step;
        busy_nxt      = 1'b0;
        out_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      acc_r       <= '0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      acc_r       <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    z_r <= z_nxt;
    v_r <= v_nxt;
  end

endmodule

`default_nettype wire

[hw/rtl/ghash_checker.sv]
`default_nettype none

module ghash_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [63:0] out_hash_hi,
  input wire logic [63:0] out_hash_lo,
  input wire logic        cfg_pready
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hash_hi) && $stable(out_hash_lo))
    else $error("result word changed while stalled");

  // the multiplier stays busy for the full digit sweep
  a_busy_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> ##16 !in_ready)
    else $error("input taken before multiply finished");

  a_busy_next: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after accept");

  // a new result appears only when the multiplier frees up
  a_done_free: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("result raised while multiplier busy");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) cfg_pready)
    else $error("pready dropped");

endmodule

bind ghash_accumulator ghash_checker u_ghash_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_hash_hi (out_hash_hi),
  .out_hash_lo (out_hash_lo),
  .cfg_pready  (cfg_pready)
);

`default_nettype wire

[tb/sv/ghash_accumulator_tb.sv]
`timescale 1ns / 100ps

module ghash_accumulator_tb;

  localparam logic [3:0] KeyHiAddr  = {ghash_pkg::RegKeyHi, 3'b000};
  localparam logic [3:0] KeyLoAddr  = {ghash_pkg::RegKeyLo, 3'b000};
  localparam int         StallLimit = 4000;
  localparam int         SettleCycles = 40;
  localparam logic [63:0] Ones64    = {64{1'b1}};

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
    logic        first;
  } block_word_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [63:0] in_block_hi;
  logic [63:0] in_block_lo;
  logic        in_first_block;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] out_hash_hi;
  logic [63:0] out_hash_lo;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [63:0] cfg_pwdata;
  logic [63:0] cfg_prdata;
  logic        cfg_pready;

  ghash_accumulator u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_block_hi    (in_block_hi),
    .in_block_lo    (in_block_lo),
    .in_first_block (in_first_block),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hash_hi    (out_hash_hi),
    .out_hash_lo    (out_hash_lo),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .cfg_pready     (cfg_pready)
  );

  block_word_t          pending_words[$];
  ghash_pkg::block_t    expected_hashes[$];
  ghash_pkg::block_t    hash_key;
  ghash_pkg::block_t    hash_accum;

  int  send_idle_pct;
  int  recv_idle_pct;
  int  words_queued;
  int  words_accepted;
  int  hashes_checked;
  int  messages_started;
  int  key_writes;
  int  mismatches;
  int  stall_cycles;
  bit  word_taken;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // GF(2^128) product in GCM bit order: bit 127 is x^0
  function automatic ghash_pkg::block_t gf_mul(ghash_pkg::block_t x, ghash_pkg::block_t h);
    ghash_pkg::block_t z;
    ghash_pkg::block_t v;
    z = '0;
    v = h;
    for (int k = 0; k < ghash_pkg::BlockW; k++) begin
      if (x[ghash_pkg::BlockW-1-k]) z ^= v;
      if (v[0]) begin
        v = (v >> 1) ^ ghash_pkg::RedPoly;
      end else begin
        v = v >> 1;
      end
    end
    return z;
  endfunction

  function automatic logic [63:0] rand_half();
    case ($urandom_range(15))
      0: return '0;
      1: return Ones64;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic note_mismatch(string what, ghash_pkg::block_t want, ghash_pkg::block_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] mismatch on %s: expected %032h, got %032h", $realtime, what, want,
               got);
    end
  endtask

  task automatic queue_word(logic [63:0] hi, logic [63:0] lo, logic first);
    block_word_t w;
    w.hi    = hi;
    w.lo    = lo;
    w.first = first;
    pending_words.push_back(w);
    words_queued++;
  endtask

  task automatic write_key_reg(logic [3:0] addr, logic [63:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic write_key(logic [63:0] hi, logic [63:0] lo);
    write_key_reg(KeyHiAddr, hi);
    write_key_reg(KeyLoAddr, lo);
  endtask

  // pause the sender until every queued word has produced its hash
  task automatic drain();
    while (words_accepted != words_queued || expected_hashes.size() != 0) @(negedge clk);
  endtask

  // predictor: track key writes and accepted words at the clock edge
  always @(posedge clk) begin : predict_hash
    ghash_pkg::block_t sum;
    word_taken = rst_n && in_valid && in_ready;
    if (!rst_n) begin
      hash_key   = '0;
      hash_accum = '0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[3])
          ghash_pkg::RegKeyHi: hash_key[127:64] = cfg_pwdata;
          ghash_pkg::RegKeyLo: hash_key[63:0]   = cfg_pwdata;
          default: ;
        endcase
        key_writes++;
      end
      if (word_taken) begin
        if (in_first_block) begin
          hash_accum = '0;
          messages_started++;
        end
        sum        = hash_accum ^ {in_block_hi, in_block_lo};
        hash_accum = gf_mul(sum, hash_key);
        expected_hashes.push_back(hash_accum);
        words_accepted++;
      end
    end
  end

  always @(negedge clk) begin : drive_words
    block_word_t w;
    if (rst_n && (!in_valid || word_taken)) begin
      if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        w = pending_words.pop_front();
        in_valid       <= 1'b1;
        in_block_hi    <= w.hi;
        in_block_lo    <= w.lo;
        in_first_block <= w.first;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : check_hash
    ghash_pkg::block_t want;
    ghash_pkg::block_t got;
    if (rst_n && out_valid && out_ready) begin
      got = {out_hash_hi, out_hash_lo};
      if (expected_hashes.size() == 0) begin
        note_mismatch("unexpected word", '0, got);
      end else begin
        want = expected_hashes.pop_front();
        if (got[127:64] !== want[127:64]) note_mismatch("hash_hi", want, got);
        if (got[63:0] !== want[63:0]) note_mismatch("hash_lo", want, got);
        hashes_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= StallLimit) begin
      $display("[%0t] no traffic for %0d cycles", $realtime, StallLimit);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : stimulus
    logic [63:0] khi;
    logic [63:0] klo;
    int          len;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_block_hi    = '0;
    in_block_lo    = '0;
    in_first_block = 1'b0;
    out_ready      = 1'b0;
    cfg_psel       = 1'b0;
    cfg_penable    = 1'b0;
    cfg_pwrite     = 1'b0;
    cfg_paddr      = '0;
    cfg_pwdata     = '0;
    send_idle_pct  = 16;
    recv_idle_pct  = 59;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset key is zero: every hash is zero; no first block right after reset
    queue_word({$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
    queue_word(Ones64, Ones64, 1'b1);
    drain();

    // identity key (x^0): hash is the running xor of the blocks
    write_key(64'h8000_0000_0000_0000, '0);
    queue_word('0, '0, 1'b1);
    queue_word(Ones64, Ones64, 1'b0);
    queue_word(64'h8000_0000_0000_0000, '0, 1'b0);
    queue_word('0, 64'h0000_0000_0000_0001, 1'b0);
    queue_word(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 1'b1);
    drain();

    // x^127 key forces the reduction on the first shift
    write_key('0, 64'h0000_0000_0000_0001);
    queue_word('0, 64'h0000_0000_0000_0001, 1'b1);
    queue_word(64'h8000_0000_0000_0000, '0, 1'b0);
    queue_word(Ones64, Ones64, 1'b0);
    drain();

    write_key(Ones64, Ones64);
    queue_word(Ones64, Ones64, 1'b1);
    queue_word('0, '0, 1'b0);
    queue_word(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, 1'b0);
    queue_word(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, 1'b1);
    drain();

    // change the key in the middle of a message
    write_key({$urandom, $urandom}, {$urandom, $urandom});
    queue_word({$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
    queue_word({$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
    drain();
    write_key_reg(KeyLoAddr, {$urandom, $urandom});
    queue_word({$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
    queue_word(Ones64, '0, 1'b0);
    drain();

    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin send_idle_pct = 16; recv_idle_pct = 59; end
        1: begin send_idle_pct = 59; recv_idle_pct = 16; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int chunk = 0; chunk < 10; chunk++) begin
        khi = rand_half();
        klo = rand_half();
        case ($urandom_range(3))
          0: write_key_reg(KeyHiAddr, khi);
          1: write_key_reg(KeyLoAddr, klo);
          2: ;
          default: write_key(khi, klo);
        endcase
        len = 0;
        for (int i = 0; i < 50; i++) begin
          // mostly multi-block messages of random length
          queue_word(rand_half(), rand_half(), len == 0 && $urandom_range(3) != 0);
          len = (len == 0) ? $urandom_range(12) : len - 1;
        end
        drain();
      end
    end

    repeat (SettleCycles) @(posedge clk);
    @(negedge clk);
    if (expected_hashes.size() != 0) begin
      mismatches++;
      $display("%0d hashes never arrived", expected_hashes.size());
    end
    $display("Hashed %0d blocks across %0d messages, %0d key register writes.",
             words_accepted, messages_started, key_writes);
    $display("Checked %0d hashes under three stall patterns, %0d mismatches.",
             hashes_checked, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[ghash_accumulator.f]
hw/rtl/ghash_pkg.sv
hw/rtl/ghash_accumulator.sv
hw/rtl/ghash_checker.sv
tb/sv/ghash_accumulator_tb.sv
